// File: rtl/entity_view_cull_lod_select_assert.svh
// Assertion helpers used by the RTL.
`ifndef ENTITY_VIEW_CULL_LOD_SELECT_ASSERT_SVH
`define ENTITY_VIEW_CULL_LOD_SELECT_ASSERT_SVH

// Clocked check, quiet while reset is low.
`define EVCLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define EVCLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/evcls_pkg.sv
package evcls_pkg;

  // register indexes on the config port
  localparam logic [2:0] CFG_CULL_DISTANCE    = 3'd0;
  localparam logic [2:0] CFG_LOD_MID_DISTANCE = 3'd1;
  localparam logic [2:0] CFG_SECTOR_HIDE      = 3'd2;
  localparam logic [2:0] CFG_SECTOR_CENTER    = 3'd3;
  localparam logic [2:0] CFG_SECTOR_HALF      = 3'd4;
  localparam logic [2:0] CFG_CAMERA_POSITION  = 3'd5;
  localparam logic [2:0] CFG_CAMERA_FORWARD   = 3'd6;

  // 4 square units in 2^-16 square units
  localparam int unsigned NEAR_D2        = 262144;
  // -0.25 in 2^-35 units is -2^33
  localparam int unsigned BEHIND_SHIFT   = 33;
  // a degenerate collider becomes a 1.0 unit box (1/256 units)
  localparam int unsigned ZERO_BOX_HALF  = 256;

  typedef enum logic [2:0] {
    RSN_KEPT     = 3'd0,
    RSN_HIDDEN   = 3'd1,
    RSN_DISTANCE = 3'd2,
    RSN_SECTOR   = 3'd3,
    RSN_BEHIND   = 3'd4,
    RSN_DETAIL   = 3'd5
  } cull_reason_t;

  typedef struct packed {
    logic [62:0] entity_position;
    logic [62:0] box_offset;
    logic [62:0] box_half_size;
    logic [62:0] entity_scale;
    logic [3:0]  entity_flags;
  } in_req_t;

  typedef struct packed {
    logic         keep;
    logic         use_lod;
    cull_reason_t cull_reason;
  } out_rsp_t;

endpackage

// File: rtl/entity_view_cull_lod_select.sv
// Pipeline: 4 work stages + output register; the first stage register is loaded at the
// accept edge.
// Throughput: one request per cycle; the whole pipeline advances together and
// freezes while the output register holds a result that is not taken.
// Reset: synchronous active-low rst_n clears all stage valid bits and every
// config register to zero; stage data registers are not reset.
module entity_view_cull_lod_select
  import evcls_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 21
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_rsp_t    out_data,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [62:0] cfg_wdata
);

  localparam int W    = COMPONENT_WIDTH;
  localparam int D1W  = W + 1;          // p - cam, p - sector center
  localparam int RDW  = W + 2;          // p + off - cam
  localparam int SQW  = 2 * W;          // one squared axis distance
  localparam int SQPW = 2 * D1W;        // full product width before trim
  localparam int CFW  = RDW + W;        // center term rd * f
  localparam int HSW  = 2 * W;          // half * scale
  localparam int EPW  = 3 * W;          // half * scale * forward
  localparam int D2W  = SQW + 2;        // sum of three squares
  localparam int CENW = CFW + 2;        // sum of three center terms
  localparam int EXTW = EPW;            // sum of three extent magnitudes
  localparam int SW   = ((CENW + 8 > EXTW) ? CENW + 8 : EXTW) + 2;
  localparam int LW   = (D2W + 2 > 42) ? D2W + 2 : 42;
  localparam logic signed [SW-1:0] BEHIND_BIAS = SW'(64'd1 << BEHIND_SHIFT);

  // ---------------------------------------------------------------------------
  // Config registers. The user must write them only while the pipeline is empty; the block does not enforce this.
  // ---------------------------------------------------------------------------
  logic [19:0] cull_r;
  logic [19:0] mid_r;
  logic        hide_r;
  logic [62:0] sec_c_r;
  logic [62:0] sec_h_r;
  logic [62:0] cam_r;
  logic [62:0] fwd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cull_r  <= '0;
      mid_r   <= '0;
      hide_r  <= 1'b0;
      sec_c_r <= '0;
      sec_h_r <= '0;
      cam_r   <= '0;
      fwd_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CULL_DISTANCE:    cull_r  <= cfg_wdata[19:0];
        CFG_LOD_MID_DISTANCE: mid_r   <= cfg_wdata[19:0];
        CFG_SECTOR_HIDE:      hide_r  <= cfg_wdata[0];
        CFG_SECTOR_CENTER:    sec_c_r <= cfg_wdata;
        CFG_SECTOR_HALF:      sec_h_r <= cfg_wdata;
        CFG_CAMERA_POSITION:  cam_r   <= cfg_wdata;
        CFG_CAMERA_FORWARD:   fwd_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Squared radii from config. Registered; an item passes the stage 1, 2 and 3 registers
  // before it reaches the compares, so these are settled long before they are used.
  logic [20:0] twice;
  logic        twice_nz;
  logic [39:0] cull_sq_r;
  logic [41:0] twice_sq_r;

  assign twice    = (mid_r != '0) ? {mid_r, 1'b0} : {1'b0, cull_r};
  assign twice_nz = (mid_r != '0) || (cull_r != '0);

  always_ff @(posedge clk) begin
    cull_sq_r  <= 40'(cull_r) * 40'(cull_r);
    twice_sq_r <= 42'(twice) * 42'(twice);
  end

  // Forward axis components, used in stages 2 and 3.
  logic signed [W-1:0] fwd [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fwd[i] = fwd_r[i*W +: W];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: all stages move together.
  // ---------------------------------------------------------------------------
  logic       adv;
  logic [4:0] v_r;   // v_r[0] stage 1 ... v_r[4] output register

  assign adv       = !v_r[4] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v_r[4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: unpack, differences, zero-box substitution.
  // ---------------------------------------------------------------------------
  logic signed [W-1:0]   p   [3];
  logic signed [W-1:0]   cam [3];
  logic signed [W-1:0]   off [3];
  logic signed [W-1:0]   sc  [3];
  logic signed [W-1:0]   hin [3];
  logic                  zero_box;
  logic signed [D1W-1:0] d1_nxt  [3];
  logic signed [RDW-1:0] rd1_nxt [3];
  logic signed [D1W-1:0] sd1_nxt [3];
  logic signed [W-1:0]   hv1_nxt [3];
  logic signed [W-1:0]   s1_nxt  [3];
  logic                  hidden1_nxt;

  always_comb begin
    zero_box = 1'b1;
    for (int i = 0; i < 3; i++) begin
      p[i]   = in_data.entity_position[i*W +: W];
      off[i] = in_data.box_offset[i*W +: W];
      hin[i] = in_data.box_half_size[i*W +: W];
      s1_nxt[i] = in_data.entity_scale[i*W +: W];
      cam[i] = cam_r[i*W +: W];
      sc[i]  = sec_c_r[i*W +: W];
      // positive half extent on any axis means a real box
      if (!hin[i][W-1] && (hin[i] != '0)) zero_box = 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      d1_nxt[i]  = D1W'(p[i]) - D1W'(cam[i]);
      rd1_nxt[i] = RDW'(p[i]) + RDW'(off[i]) - RDW'(cam[i]);
      sd1_nxt[i] = D1W'(p[i]) - D1W'(sc[i]);
      hv1_nxt[i] = zero_box ? W'(ZERO_BOX_HALF) : hin[i];
    end
    hidden1_nxt = !(in_data.entity_flags[0] && in_data.entity_flags[1]);
  end

  logic signed [D1W-1:0] d1_r  [3];
  logic signed [RDW-1:0] rd1_r [3];
  logic signed [D1W-1:0] sd1_r [3];
  logic signed [W-1:0]   hv1_r [3];
  logic signed [W-1:0]   s1_r  [3];
  logic                  hidden1_r;
  logic [1:0]            lodf1_r;   // {detail prop, has lod mesh}

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]  <= d1_nxt[i];
        rd1_r[i] <= rd1_nxt[i];
        sd1_r[i] <= sd1_nxt[i];
        hv1_r[i] <= hv1_nxt[i];
        s1_r[i]  <= s1_nxt[i];
      end
      hidden1_r <= hidden1_nxt;
      lodf1_r   <= in_data.entity_flags[3:2];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: first products, sector box test.
  // ---------------------------------------------------------------------------
  logic signed [SQPW-1:0] sqp     [3];
  logic        [SQW-1:0]  sq2_nxt [3];
  logic signed [CFW-1:0]  cf2_nxt [3];
  logic signed [HSW-1:0]  hs2_nxt [3];
  logic        [D1W-1:0]  smag    [3];
  logic signed [W-1:0]    shalf   [3];
  logic                   secf2_nxt;

  always_comb begin
    secf2_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sqp[i]     = SQPW'(d1_r[i]) * SQPW'(d1_r[i]);
      sq2_nxt[i] = sqp[i][SQW-1:0];   // |d| < 2^W, so the square fits
      cf2_nxt[i] = CFW'(rd1_r[i]) * CFW'(fwd[i]);
      hs2_nxt[i] = HSW'(hv1_r[i]) * HSW'(s1_r[i]);
      smag[i]    = sd1_r[i][D1W-1] ? D1W'(-sd1_r[i]) : D1W'(sd1_r[i]);
      shalf[i]   = sec_h_r[i*W +: W];
      // negative half extent drops the entity whenever the sector test is on
      if (shalf[i][W-1] || (smag[i] > {1'b0, shalf[i]})) secf2_nxt = hide_r;
    end
  end

  logic        [SQW-1:0] sq2_r [3];
  logic signed [CFW-1:0] cf2_r [3];
  logic signed [HSW-1:0] hs2_r [3];
  logic                  secf2_r;
  logic                  hidden2_r;
  logic [1:0]            lodf2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= sq2_nxt[i];
        cf2_r[i] <= cf2_nxt[i];
        hs2_r[i] <= hs2_nxt[i];
      end
      secf2_r   <= secf2_nxt;
      hidden2_r <= hidden1_r;
      lodf2_r   <= lodf1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: distance sum, center projection sum, extent products.
  // ---------------------------------------------------------------------------
  logic        [D2W-1:0]  d2_3_nxt;
  logic signed [CENW-1:0] cen3_nxt;
  logic signed [EPW-1:0]  e3_nxt [3];

  always_comb begin
    d2_3_nxt = D2W'(sq2_r[0]) + D2W'(sq2_r[1]) + D2W'(sq2_r[2]);
    cen3_nxt = CENW'(cf2_r[0]) + CENW'(cf2_r[1]) + CENW'(cf2_r[2]);
    for (int i = 0; i < 3; i++) begin
      e3_nxt[i] = EPW'(hs2_r[i]) * EPW'(fwd[i]);
    end
  end

  logic        [D2W-1:0]  d2_3_r;
  logic signed [CENW-1:0] cen3_r;
  logic signed [EPW-1:0]  e3_r [3];
  logic                   secf3_r;
  logic                   hidden3_r;
  logic [1:0]             lodf3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_3_r <= d2_3_nxt;
      cen3_r <= cen3_nxt;
      for (int i = 0; i < 3; i++) begin
        e3_r[i] <= e3_nxt[i];
      end
      secf3_r   <= secf2_r;
      hidden3_r <= hidden2_r;
      lodf3_r   <= lodf2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: extent magnitude sum, distance compares.
  // ---------------------------------------------------------------------------
  logic [EPW-1:0]  emag [3];
  logic [EXTW-1:0] ext4_nxt;
  logic            far4_nxt;
  logic            lodfar4_nxt;
  logic            near4_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      emag[i] = e3_r[i][EPW-1] ? EPW'(-e3_r[i]) : EPW'(e3_r[i]);
    end
    ext4_nxt    = EXTW'(emag[0]) + EXTW'(emag[1]) + EXTW'(emag[2]);
    far4_nxt    = (cull_r != '0) && (LW'(d2_3_r) > LW'(cull_sq_r));
    lodfar4_nxt = twice_nz && (LW'({d2_3_r, 2'b00}) > LW'(twice_sq_r));
    near4_nxt   = d2_3_r > D2W'(NEAR_D2);
  end

  logic        [EXTW-1:0] ext4_r;
  logic signed [CENW-1:0] cen4_r;
  logic                   far4_r;
  logic                   lodfar4_r;
  logic                   near4_r;
  logic                   secf4_r;
  logic                   hidden4_r;
  logic [1:0]             lodf4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ext4_r    <= ext4_nxt;
      cen4_r    <= cen3_r;
      far4_r    <= far4_nxt;
      lodfar4_r <= lodfar4_nxt;
      near4_r   <= near4_nxt;
      secf4_r   <= secf3_r;
      hidden4_r <= hidden3_r;
      lodf4_r   <= lodf3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: behind-camera test and priority decision into the output register.
  // center is in 2^-27 units, so it is scaled by 256 to meet the extent.
  // Behind when past the near distance and center*256 + ext < -2^33 (the biased sum is negative).
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] cen_x;
  logic signed [SW-1:0] ext_x;
  logic signed [SW-1:0] bsum;
  logic                 behind;
  out_rsp_t             out_nxt;

  always_comb begin
    cen_x  = SW'(cen4_r);
    ext_x  = SW'(ext4_r);
    bsum   = (cen_x <<< 8) + ext_x + BEHIND_BIAS;
    behind = near4_r && bsum[SW-1];

    out_nxt.keep        = 1'b0;
    out_nxt.use_lod     = 1'b0;
    out_nxt.cull_reason = RSN_KEPT;
    if (hidden4_r) begin
      out_nxt.cull_reason = RSN_HIDDEN;
    end else if (far4_r) begin
      out_nxt.cull_reason = RSN_DISTANCE;
    end else if (secf4_r) begin
      out_nxt.cull_reason = RSN_SECTOR;
    end else if (behind) begin
      out_nxt.cull_reason = RSN_BEHIND;
    end else if (lodfar4_r && !lodf4_r[0] && lodf4_r[1]) begin
      // detail prop past the LOD radius with no low-detail mesh
      out_nxt.cull_reason = RSN_DETAIL;
    end else begin
      out_nxt.keep    = 1'b1;
      out_nxt.use_lod = lodfar4_r && lodf4_r[0];
    end
  end

  out_rsp_t out_data_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`include "entity_view_cull_lod_select_assert.svh"

  `EVCLS_ASSERT(a_enter_stage1, (in_valid && in_ready) |=> v_r[0], "request lost")
  `EVCLS_ASSERT(a_stall_freeze, (v_r[3] && !adv) |=> (v_r[3] && $stable(ext4_r)), "stall moved")
  `EVCLS_ASSERT_ALWAYS(a_lod_needs_keep,
    out_valid |-> (!out_data.use_lod || out_data.keep), "use_lod set on a culled entity")
  `EVCLS_ASSERT_ALWAYS(a_keep_matches_code,
    out_valid |-> (out_data.keep == (out_data.cull_reason == RSN_KEPT)), "keep vs reason")

endmodule

// File: sim/entity_view_cull_lod_select_tb.sv
`timescale 1ns / 1ps

module entity_view_cull_lod_select_tb;
  import evcls_pkg::*;

  localparam int CW = 21;                  // bits per packed vector component
  localparam int U = 256;                  // one world unit in 1/256 steps
  localparam longint MAXC = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint MINC = -(64'sd1 <<< (CW - 1));
  localparam longint FWD1 = 64'sd1 <<< 19; // unit length on the forward axis

  // behind test: only past 2 units (4 square units in 2^-16), limit -0.25 in 2^-35
  localparam longint NEAR_SQ = 64'sd262144;
  localparam longint BEHIND_LIMIT = -(64'sd1 <<< 33);
  localparam longint UNIT_BOX = 64'sd256;

  // entity flag bits
  localparam logic [3:0] FL_VISIBLE = 4'b0001;
  localparam logic [3:0] FL_MESH = 4'b0010;
  localparam logic [3:0] FL_LOD = 4'b0100;
  localparam logic [3:0] FL_DETAIL = 4'b1000;
  localparam logic [3:0] DRAWABLE = FL_VISIBLE | FL_MESH;

  // index past the register list; writes there must be dropped
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_CULL_DISTANCE;
  logic [62:0] cfg_wdata = '0;

  // shadow copy of the register file as the block should hold it
  logic [19:0] cull_radius = '0;
  logic [19:0] lod_radius = '0;
  logic sector_on = 1'b0;
  logic [62:0] sector_mid = '0;
  logic [62:0] sector_half = '0;
  logic [62:0] eye_pos = '0;
  logic [62:0] eye_dir = '0;

  in_req_t entity_backlog[$];   // requests not yet presented
  out_rsp_t due_verdicts[$];    // predicted verdicts, oldest first

  int src_gap_pct = 0;
  int snk_stall_pct = 0;
  int src_hold = 0;
  int snk_hold = 0;
  int fail_count = 0;
  int cycle_count = 0;

  entity_view_cull_lod_select #(
    .COMPONENT_WIDTH(CW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Vector helpers
  // ---------------------------------------------------------------------------

  // signed component i (0 = x, 1 = y, 2 = z) of a packed vector
  function automatic longint axis(logic [62:0] v, int i);
    logic signed [CW-1:0] c;
    c = v[i*CW +: CW];
    return c;
  endfunction

  // pack three components, wrapping each to CW bits
  function automatic logic [62:0] vec3(longint x, longint y, longint z);
    return {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [62:0] raw63();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  // uniform in [-m, m]
  function automatic longint rand_in(longint m);
    return longint'($urandom_range(0, 32'(2 * m))) - m;
  endfunction

  // ---------------------------------------------------------------------------
  // Verdict predictor. Exact integer math: every product fits in 64 bits for
  // 21-bit components (worst case the extent sum, about 3 * 2^60).
  // ---------------------------------------------------------------------------
  function automatic out_rsp_t visibility_of(in_req_t e);
    out_rsp_t v;
    longint p[3];
    longint eye[3];
    longint dir[3];
    longint d, d2, center, extent, hv, twice, cull_l, mid_l;
    bit zero_box;
    int i;
    v.keep = 1'b0;
    v.use_lod = 1'b0;
    v.cull_reason = RSN_HIDDEN;
    cull_l = cull_radius;
    mid_l = lod_radius;

    // hidden or nothing to draw
    if (!e.entity_flags[0] || !e.entity_flags[1]) return v;

    d2 = 0;
    for (i = 0; i < 3; i++) begin
      p[i] = axis(e.entity_position, i);
      eye[i] = axis(eye_pos, i);
      dir[i] = axis(eye_dir, i);
      d = p[i] - eye[i];
      d2 += d * d;
    end

    if (cull_l > 0 && d2 > cull_l * cull_l) begin
      v.cull_reason = RSN_DISTANCE;
      return v;
    end

    // sector box: a negative half extent always drops the entity
    if (sector_on) begin
      for (i = 0; i < 3; i++) begin
        d = p[i] - axis(sector_mid, i);
        hv = axis(sector_half, i);
        if (hv < 0 || magnitude(d) > hv) begin
          v.cull_reason = RSN_SECTOR;
          return v;
        end
      end
    end

    // no positive half extent at all -> unit box
    zero_box = 1'b1;
    for (i = 0; i < 3; i++)
      if (axis(e.box_half_size, i) > 0) zero_box = 1'b0;

    center = 0;
    extent = 0;
    for (i = 0; i < 3; i++) begin
      hv = zero_box ? UNIT_BOX : axis(e.box_half_size, i);
      d = p[i] + axis(e.box_offset, i) - eye[i];
      center += d * dir[i];
      extent += magnitude(hv * axis(e.entity_scale, i) * dir[i]);
    end
    // center is in 2^-27, extent in 2^-35
    if (d2 > NEAR_SQ && center * 256 + extent < BEHIND_LIMIT) begin
      v.cull_reason = RSN_BEHIND;
      return v;
    end

    // LOD radius defaults to half the cull radius; compare doubled to stay exact
    twice = (mid_l != 0) ? 2 * mid_l : cull_l;
    if (twice > 0 && 4 * d2 > twice * twice) begin
      if (e.entity_flags[2]) begin
        v.use_lod = 1'b1;
      end else if (e.entity_flags[3]) begin
        v.cull_reason = RSN_DETAIL;
        return v;
      end
    end

    v.keep = 1'b1;
    v.cull_reason = RSN_KEPT;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: presents backlog entries, inserts idle bursts between
  // requests, and predicts each request at the edge it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_hold = 0;
    end else begin
      if (in_valid && in_ready)
        due_verdicts.insert(due_verdicts.size(), visibility_of(in_data));
      // slot is free when nothing is shown or the shown request just went in
      if (!in_valid || in_ready) begin
        if (src_hold > 0) begin
          src_hold--;
          in_valid <= 1'b0;
        end else if (entity_backlog.size() != 0 && $urandom_range(0, 99) < src_gap_pct) begin
          src_hold = $urandom_range(0, 7);   // start a burst of idle cycles
          in_valid <= 1'b0;
        end else if (entity_backlog.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= entity_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks every accepted result against the oldest
  // prediction and applies random backpressure bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    out_rsp_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      snk_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_verdicts.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: keep=%0b lod=%0b reason=%0d",
                     out_data.keep, out_data.use_lod, out_data.cull_reason);
          fail_count++;
        end else begin
          want = due_verdicts.pop_front();
          if (out_data.keep !== want.keep || out_data.use_lod !== want.use_lod ||
              out_data.cull_reason !== want.cull_reason) begin
            if (fail_count < 10)
              $display("mismatch: exp keep=%0b lod=%0b reason=%0d, got keep=%0b lod=%0b reason=%0d",
                       want.keep, want.use_lod, want.cull_reason,
                       out_data.keep, out_data.use_lod, out_data.cull_reason);
            fail_count++;
          end
        end
      end
      if (snk_hold > 0) begin
        snk_hold--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < snk_stall_pct) begin
        snk_hold = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register programming (only while the pipeline is empty)
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [62:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    // narrow registers keep only their low bits
    case (idx)
      CFG_CULL_DISTANCE:    cull_radius = value[19:0];
      CFG_LOD_MID_DISTANCE: lod_radius = value[19:0];
      CFG_SECTOR_HIDE:      sector_on = value[0];
      CFG_SECTOR_CENTER:    sector_mid = value;
      CFG_SECTOR_HALF:      sector_half = value;
      CFG_CAMERA_POSITION:  eye_pos = value;
      CFG_CAMERA_FORWARD:   eye_dir = value;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [62:0] cull, input logic [62:0] mid,
                              input logic [62:0] hide, input logic [62:0] center,
                              input logic [62:0] half, input logic [62:0] eye,
                              input logic [62:0] dir);
    write_reg(CFG_CULL_DISTANCE, cull);
    write_reg(CFG_LOD_MID_DISTANCE, mid);
    write_reg(CFG_SECTOR_HIDE, hide);
    write_reg(CFG_SECTOR_CENTER, center);
    write_reg(CFG_SECTOR_HALF, half);
    write_reg(CFG_CAMERA_POSITION, eye);
    write_reg(CFG_CAMERA_FORWARD, dir);
    write_reg(CFG_UNUSED, raw63());
  endtask

  // random frame setup, mostly sane: camera near origin, sector around it
  task automatic random_settings();
    logic [19:0] cull, mid;
    logic [62:0] noise, eye, dir, center, half;
    longint c[3];
    int i;
    noise = raw63();
    case ($urandom_range(0, 5))
      0: cull = '0;
      1: cull = 20'hFFFFF;
      default: cull = 20'($urandom_range(2 * U, 200 * U));
    endcase
    case ($urandom_range(0, 3))
      0: mid = '0;
      1: mid = 20'hFFFFF;
      2: mid = 20'($urandom_range(0, 20'hFFFFF));
      default: mid = 20'($urandom_range(0, 32'(cull)));
    endcase
    if ($urandom_range(0, 5) == 0)
      eye = raw63();
    else
      eye = vec3(rand_in(64 * U), rand_in(64 * U), rand_in(64 * U));
    case ($urandom_range(0, 3))
      0: dir = raw63();
      1: dir = vec3(rand_in(FWD1), rand_in(FWD1), rand_in(FWD1));
      default: begin
        c[0] = 0;
        c[1] = 0;
        c[2] = 0;
        c[$urandom_range(0, 2)] = $urandom_range(0, 1) ? FWD1 : -FWD1;
        dir = vec3(c[0], c[1], c[2]);
      end
    endcase
    for (i = 0; i < 3; i++) c[i] = axis(eye, i) + rand_in(16 * U);
    center = vec3(c[0], c[1], c[2]);
    if ($urandom_range(0, 3) == 0)
      half = raw63();   // often has a negative extent
    else
      half = vec3($urandom_range(0, 64 * U), $urandom_range(0, 64 * U),
                  $urandom_range(0, 64 * U));
    // sometimes leave junk above the narrow register widths
    program_regs($urandom_range(0, 1) ? {noise[62:20], cull} : 63'(cull),
                 $urandom_range(0, 1) ? {noise[62:20], mid} : 63'(mid),
                 $urandom_range(0, 1) ? noise : 63'($urandom_range(0, 1)),
                 center, half, eye, dir);
  endtask

  function automatic in_req_t entity(logic [62:0] pos, logic [62:0] off, logic [62:0] half,
                                     logic [62:0] scale, logic [3:0] flags);
    in_req_t e;
    e.entity_position = pos;
    e.box_offset = off;
    e.box_half_size = half;
    e.entity_scale = scale;
    e.entity_flags = flags;
    return e;
  endfunction

  // append one request at the tail of the backlog
  task automatic add_entity(input in_req_t e);
    entity_backlog.insert(entity_backlog.size(), e);
  endtask

  // mostly drawable entities scattered around the camera, some pure noise
  function automatic in_req_t random_entity();
    in_req_t e;
    longint reach;
    longint c[3];
    int i;
    if ($urandom_range(0, 99) < 15) begin
      e.entity_position = raw63();
      e.box_offset = raw63();
      e.box_half_size = raw63();
      e.entity_scale = raw63();
      e.entity_flags = 4'($urandom);
      return e;
    end
    case ($urandom_range(0, 3))
      0: reach = 4 * U;
      1: reach = 32 * U;
      2: reach = 256 * U;
      default: reach = 64'sd1 <<< 20;
    endcase
    for (i = 0; i < 3; i++) c[i] = axis(eye_pos, i) + rand_in(reach);
    e.entity_position = vec3(c[0], c[1], c[2]);
    if ($urandom_range(0, 3) == 0)
      e.box_offset = raw63();
    else
      e.box_offset = vec3(rand_in(4 * U), rand_in(4 * U), rand_in(4 * U));
    case ($urandom_range(0, 7))
      0: e.box_half_size = '0;
      1: e.box_half_size = vec3(rand_in(U), rand_in(U), rand_in(U)); // often degenerate
      2: e.box_half_size = raw63();
      default: e.box_half_size = vec3($urandom_range(0, 8 * U), $urandom_range(0, 8 * U),
                                      $urandom_range(0, 8 * U));
    endcase
    case ($urandom_range(0, 7))
      0: e.entity_scale = raw63();
      1: e.entity_scale = vec3(rand_in(4 * U), rand_in(4 * U), rand_in(4 * U));
      default: e.entity_scale = vec3($urandom_range(0, 4 * U), $urandom_range(0, 4 * U),
                                     $urandom_range(0, 4 * U));
    endcase
    if ($urandom_range(0, 9) == 0)
      e.entity_flags = 4'($urandom);
    else
      e.entity_flags = DRAWABLE | {2'($urandom), 2'b00};
    return e;
  endfunction

  // wait until every request went in and every verdict came back
  task automatic drain();
    while (entity_backlog.size() != 0 || in_valid || due_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    src_gap_pct = 20;
    snk_stall_pct = 20;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frame: cull at 100 units (LOD at the default 50), sector box half extents
    // 120 x 120 x 30 around the origin, camera at origin looking down +x.
    program_regs(63'(100 * U), '0, 63'd1, '0, vec3(120 * U, 120 * U, 30 * U), '0,
                 vec3(FWD1, 0, 0));
    // hidden / meshless
    add_entity(entity(vec3(10 * U, 0, 0), '0, '0, vec3(U, U, U), 4'b0000));
    add_entity(entity(vec3(10 * U, 0, 0), '0, '0, vec3(U, U, U), FL_VISIBLE));
    add_entity(entity(vec3(10 * U, 0, 0), '0, '0, vec3(U, U, U),
                      FL_MESH | FL_LOD | FL_DETAIL));
    // zero box in front, kept
    add_entity(entity(vec3(10 * U, 0, 0), '0, '0, vec3(U, U, U), DRAWABLE));
    // distance: well past, exactly on the radius, one step past
    add_entity(entity(vec3(150 * U, 0, 0), '0, '0, vec3(U, U, U), DRAWABLE));
    add_entity(entity(vec3(100 * U, 0, 0), '0, '0, vec3(U, U, U), DRAWABLE));
    add_entity(entity(vec3(100 * U, 0, 1), '0, '0, vec3(U, U, U), DRAWABLE));
    // LOD band: lod mesh, detail prop dropped, lod beats detail, inside, on the edge
    add_entity(entity(vec3(60 * U, 0, 0), '0, '0, vec3(U, U, U),
                      DRAWABLE | FL_LOD));
    add_entity(entity(vec3(60 * U, 0, 0), '0, '0, vec3(U, U, U),
                      DRAWABLE | FL_DETAIL));
    add_entity(entity(vec3(60 * U, 0, 0), '0, '0, vec3(U, U, U), 4'b1111));
    add_entity(entity(vec3(40 * U, 0, 0), '0, '0, vec3(U, U, U),
                      DRAWABLE | FL_DETAIL));
    add_entity(entity(vec3(50 * U, 0, 0), '0, '0, vec3(U, U, U),
                      DRAWABLE | FL_DETAIL));
    // sector: outside on z, exactly on the -z face
    add_entity(entity(vec3(0, 0, 50 * U), '0, '0, vec3(U, U, U), DRAWABLE));
    add_entity(entity(vec3(0, 0, -30 * U), '0, '0, vec3(U, U, U), DRAWABLE));
    // behind camera, and the near exemption below / at 2 units
    add_entity(entity(vec3(-10 * U, 0, 0), '0, vec3(U, U, U), vec3(U, U, U),
                      DRAWABLE));
    add_entity(entity(vec3(-U, 0, 0), '0, vec3(U, U, U), vec3(U, U, U),
                      DRAWABLE));
    add_entity(entity(vec3(-2 * U, 0, 0), '0, vec3(U, U, U), vec3(U, U, U),
                      DRAWABLE));
    // box straddling the camera plane; negative extents fall back to a unit box
    add_entity(entity(vec3(-3 * U, 0, 0), '0, vec3(4 * U, 0, 0), vec3(U, U, U),
                      DRAWABLE));
    add_entity(entity(vec3(-3 * U, 0, 0), '0, vec3(-U, -U, 0), vec3(U, U, U),
                      DRAWABLE));
    // collider offset moves the box in front of / behind the camera
    add_entity(entity(vec3(-3 * U, 0, 0), vec3(10 * U, 0, 0), vec3(U, U, U),
                      vec3(U, U, U), DRAWABLE));
    add_entity(entity(vec3(5 * U, 0, 0), vec3(-10 * U, 0, 0), vec3(U, U, U),
                      vec3(U, U, U), DRAWABLE));
    // center exactly at -0.25 (kept) and one step further (behind), no extent
    add_entity(entity(vec3(-3 * U, 0, 0), vec3(3 * U - 64, 0, 0),
                      vec3(U, 0, 0), '0, DRAWABLE));
    add_entity(entity(vec3(-3 * U, 0, 0), vec3(3 * U - 65, 0, 0),
                      vec3(U, 0, 0), '0, DRAWABLE));
    // field extremes
    add_entity(entity('1, '0, '1, '1, 4'b1111));
    add_entity(entity(vec3(MAXC, MAXC, MAXC), vec3(MINC, MINC, MINC),
                      vec3(MAXC, MAXC, MAXC), vec3(MAXC, MAXC, MAXC), 4'b1111));
    add_entity(entity(vec3(-10 * U, 0, 0), vec3(MINC, MINC, MINC),
                      vec3(MAXC, MAXC, MAXC), vec3(MINC, MINC, MINC), DRAWABLE));
    drain();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        // largest radii, huge sector, most negative forward; junk in upper bits
        0: program_regs('1, '1, '1, '0, vec3(MAXC, MAXC, MAXC),
                        vec3(rand_in(64 * U), rand_in(64 * U), rand_in(64 * U)),
                        vec3(MINC, MINC, MINC));
        // distance cull and LOD off, sector off
        1: program_regs('0, '0, '0, '1, '1, vec3(MAXC, MINC, MAXC), vec3(MAXC, MAXC, MAXC));
        default: random_settings();
      endcase
      // one middle phase and the closing phase run without idling
      if (phase == 4 || phase == RANDOM_PHASES - 1) begin
        src_gap_pct = 0;
        snk_stall_pct = 0;
      end else begin
        src_gap_pct = $urandom_range(5, 40);
        snk_stall_pct = $urandom_range(5, 40);
      end
      repeat (ITEMS_PER_PHASE) add_entity(random_entity());
      drain();
    end

    // give stray results time to show up
    repeat (10) @(posedge clk);
    if (fail_count == 0 && due_verdicts.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
